// ----- rtl/hzoe_pkg.sv -----
package hzoe_pkg;

    // Default sizing of the encoder
    localparam int HZOE_MAX_LEVELS = 32;
    localparam int HZOE_COORD_BITS = 16;

    // Fixed field widths
    localparam int COORD_W     = 16;
    localparam int ADDR_W      = 31;
    localparam int LEVEL_W     = 6;
    localparam int LEN_W       = 5;
    localparam int OFFSET_W    = 48;
    localparam int EXT_W       = 16;
    localparam int PATTERN_W   = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Axis selector codes in the level pattern
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_COUNT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_PATTERN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_CUTOFF = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_MAJOR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATCH_ORIGIN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATCH_EXTENT = 3'd5;

    // Per-item state handed from cell to cell.
    // found: the first set interleaved bit has been seen (it is dropped);
    // acc/len: address bits gathered after it.
    typedef struct packed {
        logic               found;
        logic [LEN_W-1:0]   len;
        logic [ADDR_W-1:0]  acc;
        logic [COORD_W-1:0] orig_x;
        logic [COORD_W-1:0] orig_y;
        logic [COORD_W-1:0] orig_z;
    } hzoe_track_t;

    // Finished address part of a result
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [LEVEL_W-1:0] level;
        logic               skip;
        logic               err;
    } hzoe_head_t;

endpackage

// ----- rtl/hz_order_encoder_top.sv -----
// Hierarchical Z-order address encoder. Each transfer on the coord channel
// carries one x/y/z sample coordinate and yields exactly one transfer on the
// result channel with the HZ address, its level, the skip flag, the linear
// offset inside the patch and a range error flag, in input order. The block
// takes one coordinate per clock while coord_stall is low. Its pipeline is
// a row of MAX_LEVELS - 1 cells, one per hierarchy level above level 0, each
// taking one coordinate bit when its level is in use, followed by three
// stages that compute the patch offset (differences and extent product,
// partial products, final sum). Results leave from an output register;
// coord_stall rises only while a result sits there stalled. Configuration
// writes are always accepted (cfg_ready is tied high) and must be made while
// no item is in flight. There is no clearing pass after reset.
module hz_order_encoder_top #(
    parameter int MAX_LEVELS = hzoe_pkg::HZOE_MAX_LEVELS,
    parameter int COORD_BITS = hzoe_pkg::HZOE_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hzoe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hzoe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                coord_valid,
    output logic                                coord_stall,
    input  logic [hzoe_pkg::COORD_W-1:0]        coord_x,
    input  logic [hzoe_pkg::COORD_W-1:0]        coord_y,
    input  logic [hzoe_pkg::COORD_W-1:0]        coord_z,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [hzoe_pkg::ADDR_W-1:0]         hz_address,
    output logic [hzoe_pkg::LEVEL_W-1:0]        addr_level,
    output logic                                skipped,
    output logic [hzoe_pkg::OFFSET_W-1:0]       local_offset,
    output logic                                range_error
);
    import hzoe_pkg::*;

    localparam int CELLS = MAX_LEVELS - 1;

    // Configuration registers
    logic [LEVEL_W-1:0]   level_count_reg;
    logic [PATTERN_W-1:0] axis_pattern_reg;
    logic [LEVEL_W-1:0]   level_cutoff_reg;
    logic                 column_major_reg;
    logic [OFFSET_W-1:0]  patch_origin_reg;
    logic [OFFSET_W-1:0]  patch_extent_reg;

    logic                 adv;
    logic [LEVEL_W-1:0]   n_eff;
    logic [1:0]           step_sel [CELLS];
    logic                 step_on  [CELLS];

    logic                       chain_valid [CELLS+1];
    hzoe_track_t                chain_track [CELLS+1];
    logic [2:0][COORD_BITS-1:0] chain_rem   [CELLS+1];

    hzoe_track_t          last;
    hzoe_head_t           head;
    hzoe_head_t           out_head;
    logic signed [LEVEL_W+1:0] skip_limit;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg  <= LEVEL_W'(1);
            axis_pattern_reg <= '0;
            level_cutoff_reg <= '0;
            column_major_reg <= 1'b0;
            patch_origin_reg <= '0;
            patch_extent_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEVEL_COUNT:  level_count_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_AXIS_PATTERN: axis_pattern_reg <= cfg_data[PATTERN_W-1:0];
                CFG_LEVEL_CUTOFF: level_cutoff_reg <= cfg_data[LEVEL_W-1:0];
                CFG_COLUMN_MAJOR: column_major_reg <= cfg_data[0];
                CFG_PATCH_ORIGIN: patch_origin_reg <= cfg_data[OFFSET_W-1:0];
                CFG_PATCH_EXTENT: patch_extent_reg <= cfg_data[OFFSET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Whole pipeline moves together; it halts only on a stalled result
    assign adv         = !result_valid || !result_stall;
    assign coord_stall = !adv;

    // Effective level count, clamped to 1..MAX_LEVELS
    always_comb
    begin
        if (level_count_reg == '0)
        begin
            n_eff = LEVEL_W'(1);
        end
        else if (level_count_reg > LEVEL_W'(MAX_LEVELS))
        begin
            n_eff = LEVEL_W'(MAX_LEVELS);
        end
        else
        begin
            n_eff = level_count_reg;
        end
    end

    // Cell s handles level n_eff-1-s, deepest level first
    for (genvar s = 0; s < CELLS; s++)
    begin : g_sel
        logic [LEVEL_W-1:0] lv;
        assign lv          = n_eff - LEVEL_W'(s + 1);
        assign step_sel[s] = axis_pattern_reg[{lv[4:0], 1'b0} +: 2];
        assign step_on[s]  = n_eff >= LEVEL_W'(s + 2);
    end

    // Chain head from the coord ports
    assign chain_valid[0] = coord_valid;
    assign chain_track[0] = {1'b0, LEN_W'(0), ADDR_W'(0),
                             COORD_W'(coord_x[COORD_BITS-1:0]),
                             COORD_W'(coord_y[COORD_BITS-1:0]),
                             COORD_W'(coord_z[COORD_BITS-1:0])};
    assign chain_rem[0]   = {coord_z[COORD_BITS-1:0], coord_y[COORD_BITS-1:0],
                             coord_x[COORD_BITS-1:0]};

    // Row of level cells
    for (genvar s = 0; s < CELLS; s++)
    begin : g_cell
        hzoe_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[s]),
            .in_track  (chain_track[s]),
            .in_rem    (chain_rem[s]),
            .sel       (step_sel[s]),
            .on        (step_on[s]),
            .out_valid (chain_valid[s+1]),
            .out_track (chain_track[s+1]),
            .out_rem   (chain_rem[s+1])
        );
    end

    // Marker bit, level, skip test and range check
    always_comb
    begin
        last = chain_track[CELLS];
        if (last.found)
        begin
            head.addr  = last.acc | (ADDR_W'(1) << last.len);
            head.level = LEVEL_W'(last.len) + LEVEL_W'(1);
        end
        else
        begin
            head.addr  = '0;
            head.level = '0;
        end
        skip_limit = $signed({2'b00, n_eff}) - $signed({2'b00, level_cutoff_reg});
        head.skip  = $signed({2'b00, head.level}) >= skip_limit;
        head.err   = |chain_rem[CELLS];
    end

    hzoe_offset u_offset (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (chain_valid[CELLS]),
        .in_head      (head),
        .orig_x       (last.orig_x),
        .orig_y       (last.orig_y),
        .orig_z       (last.orig_z),
        .column_major (column_major_reg),
        .patch_origin (patch_origin_reg),
        .patch_extent (patch_extent_reg),
        .out_valid    (result_valid),
        .out_head     (out_head),
        .offset       (local_offset)
    );

    assign hz_address  = out_head.addr;
    assign addr_level  = out_head.level;
    assign skipped     = out_head.skip;
    assign range_error = out_head.err;

endmodule

// ----- rtl/hzoe_cell.sv -----
module hzoe_cell #(
    parameter int COORD_BITS = hzoe_pkg::HZOE_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  hzoe_pkg::hzoe_track_t        in_track,
    input  logic [2:0][COORD_BITS-1:0]   in_rem,
    input  logic [1:0]                   sel,
    input  logic                         on,
    output logic                         out_valid,
    output hzoe_pkg::hzoe_track_t        out_track,
    output logic [2:0][COORD_BITS-1:0]   out_rem
);
    import hzoe_pkg::*;

    logic                       valid_reg;
    hzoe_track_t                track_reg;
    hzoe_track_t                track_next;
    logic [2:0][COORD_BITS-1:0] rem_reg;
    logic [2:0][COORD_BITS-1:0] rem_next;
    logic                       take_bit;

    // Take one coordinate bit for this level and fold it into the address
    always_comb
    begin
        track_next = in_track;
        rem_next   = in_rem;
        take_bit   = 1'b0;
        if (on)
        begin
            case (sel)
                AXIS_X:
                begin
                    take_bit         = in_rem[AXIS_X][0];
                    rem_next[AXIS_X] = in_rem[AXIS_X] >> 1;
                end
                AXIS_Y:
                begin
                    take_bit         = in_rem[AXIS_Y][0];
                    rem_next[AXIS_Y] = in_rem[AXIS_Y] >> 1;
                end
                AXIS_Z:
                begin
                    take_bit         = in_rem[AXIS_Z][0];
                    rem_next[AXIS_Z] = in_rem[AXIS_Z] >> 1;
                end
                default:
                begin
                    take_bit = 1'b0;
                end
            endcase
            // leading zeros and the first one are shifted out of the address
            if (in_track.found)
            begin
                track_next.acc = in_track.acc | (ADDR_W'(take_bit) << in_track.len);
                track_next.len = in_track.len + LEN_W'(1);
            end
            else if (take_bit)
            begin
                track_next.found = 1'b1;
            end
        end
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            track_reg <= track_next;
            rem_reg   <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_track = track_reg;
    assign out_rem   = rem_reg;

endmodule

// ----- rtl/hzoe_offset.sv -----
module hzoe_offset (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  hzoe_pkg::hzoe_head_t              in_head,
    input  logic [hzoe_pkg::COORD_W-1:0]      orig_x,
    input  logic [hzoe_pkg::COORD_W-1:0]      orig_y,
    input  logic [hzoe_pkg::COORD_W-1:0]      orig_z,
    input  logic                              column_major,
    input  logic [hzoe_pkg::OFFSET_W-1:0]     patch_origin,
    input  logic [hzoe_pkg::OFFSET_W-1:0]     patch_extent,
    output logic                              out_valid,
    output hzoe_pkg::hzoe_head_t              out_head,
    output logic [hzoe_pkg::OFFSET_W-1:0]     offset
);
    import hzoe_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int FG_W   = 2 * EXT_W;
    localparam int P1_W   = FG_W + 1 + DIFF_W;
    localparam int P2_W   = EXT_W + 1 + DIFF_W;

    // Stage A signals
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic [EXT_W-1:0]         ex;
    logic [EXT_W-1:0]         ey;
    logic [EXT_W-1:0]         ez;
    logic [EXT_W-1:0]         f_next;
    logic [FG_W-1:0]          fg_next;
    logic signed [DIFF_W-1:0] do_next;
    logic signed [DIFF_W-1:0] di_next;

    logic                     a_valid_reg;
    hzoe_head_t               a_head_reg;
    logic [FG_W-1:0]          fg_reg;
    logic [EXT_W-1:0]         f_reg;
    logic signed [DIFF_W-1:0] do_reg;
    logic signed [DIFF_W-1:0] dm_reg;
    logic signed [DIFF_W-1:0] di_reg;

    // Stage B signals
    logic signed [P1_W-1:0]   p1_next;
    logic signed [P2_W-1:0]   p2_next;
    logic                     b_valid_reg;
    hzoe_head_t               b_head_reg;
    logic [OFFSET_W-1:0]      p1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic signed [DIFF_W-1:0] b_di_reg;

    // Stage C signals
    logic [OFFSET_W-1:0]      offset_next;
    logic                     c_valid_reg;
    hzoe_head_t               c_head_reg;
    logic [OFFSET_W-1:0]      offset_reg;

    // Stage A: origin differences and the extent product
    always_comb
    begin
        dx = $signed({1'b0, orig_x}) - $signed({1'b0, patch_origin[EXT_W-1:0]});
        dy = $signed({1'b0, orig_y}) - $signed({1'b0, patch_origin[2*EXT_W-1:EXT_W]});
        dz = $signed({1'b0, orig_z}) - $signed({1'b0, patch_origin[3*EXT_W-1:2*EXT_W]});
        ex = patch_extent[EXT_W-1:0];
        ey = patch_extent[2*EXT_W-1:EXT_W];
        ez = patch_extent[3*EXT_W-1:2*EXT_W];
        if (column_major)
        begin
            f_next  = ez;
            do_next = dx;
            di_next = dz;
        end
        else
        begin
            f_next  = ex;
            do_next = dz;
            di_next = dx;
        end
        fg_next = f_next * ey;
    end

    // Stage B: the two partial products
    always_comb
    begin
        p1_next = $signed({1'b0, fg_reg}) * do_reg;
        p2_next = $signed({1'b0, f_reg}) * dm_reg;
    end

    // Stage C: final sum modulo the offset width
    always_comb
    begin
        offset_next = p1_reg
                    + {{(OFFSET_W-P2_W){p2_reg[P2_W-1]}}, p2_reg}
                    + {{(OFFSET_W-DIFF_W){b_di_reg[DIFF_W-1]}}, b_di_reg};
    end

    // Stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_head_reg <= in_head;
            fg_reg     <= fg_next;
            f_reg      <= f_next;
            do_reg     <= do_next;
            dm_reg     <= dy;
            di_reg     <= di_next;

            b_head_reg <= a_head_reg;
            p1_reg     <= p1_next[OFFSET_W-1:0];
            p2_reg     <= p2_next;
            b_di_reg   <= di_reg;

            c_head_reg <= b_head_reg;
            offset_reg <= offset_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_head  = c_head_reg;
    assign offset    = offset_reg;

endmodule

// ----- rtl/hzoe_checker.sv -----
module hzoe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          coord_stall,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [hzoe_pkg::ADDR_W-1:0]   hz_address,
    input logic [hzoe_pkg::LEVEL_W-1:0]  addr_level
);
    import hzoe_pkg::*;

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(hz_address)
                                         && $stable(addr_level))
        else $error("stalled result changed");

    // Input backpressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        coord_stall == (result_valid && result_stall))
        else $error("coord_stall does not follow the output register");

    // Zero address exactly when the level is zero
    a_zero_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((hz_address == '0) == (addr_level == '0)))
        else $error("address and level disagree on zero");

    // Level is the bit length of the address
    a_bit_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (addr_level != '0)
        |-> (hz_address >> (addr_level - LEVEL_W'(1))) == ADDR_W'(1))
        else $error("level is not the address bit length");

endmodule

bind hz_order_encoder_top hzoe_checker u_hzoe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .coord_stall  (coord_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hz_address   (hz_address),
    .addr_level   (addr_level)
);
